[rtl/wrc_pkg.sv]
package wrc_pkg;

  localparam int unsigned AddrWidthDefault = 18;
  localparam int unsigned StartWidth       = 18;
  localparam int unsigned SizeWidth        = 19;
  localparam int unsigned CfgDataWidth     = 19;
  localparam int unsigned SumWidth         = 16;

  localparam logic [SumWidth-1:0] SumInit   = 16'h0013;
  localparam logic [SumWidth-1:0] AlignMask = 16'hFFFC;

  typedef enum logic [0:0] {
    CFG_REGION_START = 1'b0,
    CFG_REGION_SIZE  = 1'b1
  } cfg_reg_e;

  // Word handed from the address stage to the accumulator.
  typedef struct packed {
    logic [7:0]          data;
    logic                last;
    logic [SumWidth-1:0] stored;
    logic [SumWidth-1:0] weight;
  } stage_word_t;

  function automatic logic [SumWidth-1:0] swap_bytes(input logic [SumWidth-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

[rtl/wrc_front.sv]
module wrc_front import wrc_pkg::*; #(
  parameter int unsigned ADDRESS_WIDTH = AddrWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  cfg_reg_e                cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    in_accept_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    last_byte_i,
  input  logic [SumWidth-1:0]     stored_checksum_i,
  input  logic                    advance_i,
  output logic                    word_valid_o,
  output stage_word_t             word_o
);

  logic [StartWidth-1:0]    start_q;
  logic [SizeWidth-1:0]     size_q;
  logic [ADDRESS_WIDTH-1:0] addr_q, addr_d;
  logic                     valid_q, valid_d;
  stage_word_t              word_q;

  logic [31:0]              addr_ext;
  logic [31:0]              start_ext;
  logic [31:0]              wstart_ext;
  logic [SumWidth-1:0]      weight;

  assign addr_ext   = 32'(addr_q);
  assign start_ext  = 32'(start_q);
  assign wstart_ext = 32'(cfg_wdata_i[StartWidth-1:0]);

  // Only the low 16 bits survive, so work the weight at that width.
  assign weight = size_q[SumWidth-1:0] - ((addr_ext[SumWidth-1:0] & AlignMask)
                  - start_q[SumWidth-1:0]);

  always_comb begin
    addr_d  = addr_q;
    valid_d = valid_q;
    if (advance_i) valid_d = 1'b0;
    if (in_accept_i) begin
      valid_d = 1'b1;
      if (last_byte_i) addr_d = start_ext[ADDRESS_WIDTH-1:0];
      else             addr_d = addr_q + ADDRESS_WIDTH'(1);
    end
    if (cfg_we_i && cfg_index_i == CFG_REGION_START) begin
      addr_d = wstart_ext[ADDRESS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      size_q  <= SizeWidth'(1);
      addr_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      addr_q  <= addr_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_REGION_START: start_q <= cfg_wdata_i[StartWidth-1:0];
          CFG_REGION_SIZE:  size_q  <= cfg_wdata_i;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      word_q.data   <= data_byte_i;
      word_q.last   <= last_byte_i;
      word_q.stored <= stored_checksum_i;
      word_q.weight <= weight;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

[rtl/wrc_accum.sv]
module wrc_accum import wrc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                word_valid_i,
  input  stage_word_t         word_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SumWidth-1:0] checksum_o,
  output logic                matches_res_o
);

  logic [SumWidth-1:0] sum_q, sum_d;
  logic [SumWidth-1:0] sum_next;
  logic [SumWidth-1:0] swapped;
  logic [SumWidth-1:0] prod;
  logic                out_valid_q, out_valid_d;
  logic                out_free;
  logic [SumWidth-1:0] checksum_q;
  logic                matches_q;

  // Only the low 16 bits of the product reach the sum.
  assign prod     = word_i.weight * {8'd0, word_i.data};
  assign sum_next = sum_q + prod;
  assign swapped  = swap_bytes(sum_next);

  assign out_free  = !out_valid_q || out_ready_i;
  assign advance_o = word_valid_i && (!word_i.last || out_free);

  always_comb begin
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (advance_o) begin
      if (word_i.last) begin
        sum_d       = SumInit;
        out_valid_d = 1'b1;
      end else begin
        sum_d = sum_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= SumInit;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && word_i.last) begin
      checksum_q <= swapped;
      matches_q  <= (swapped == word_i.stored);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign checksum_o    = checksum_q;
  assign matches_res_o = matches_q;

endmodule

[rtl/weighted_region_checksum.sv]
// Weighted region checksum. Feed the bytes of one region in address order,
// one word per byte, and flag the final byte with last_byte_i, carrying the
// stored checksum on that same word. Each byte is weighted by region_size
// minus the offset of its 4-byte-aligned address from region_start (16 bits)
// and summed modulo 2^16 onto a seed of 0x13. On the final byte one result
// word leaves: the sum byte-swapped and a match flag against the stored
// value; the sum and the address then reload for the next region. The block
// takes one byte every cycle: an address stage computes the weight into an
// input register, and a single 16x8 multiply-accumulate closes the sum loop.
// The final byte passes through the input register; its result then becomes
// valid in an output register and sits there while further bytes keep
// flowing. Input stalls only when a second final byte meets a result that
// has not yet been taken.
// Write region_start (index 0) or region_size (index 1) only while idle;
// writing region_start reloads the byte address at once.
module weighted_region_checksum import wrc_pkg::*; #(
  parameter int unsigned ADDRESS_WIDTH = AddrWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  cfg_reg_e                cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  // byte channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    last_byte_i,
  input  logic [SumWidth-1:0]     stored_checksum_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SumWidth-1:0]     checksum_o,
  output logic                    matches_res_o
);

  logic        in_accept;
  logic        word_valid;
  logic        advance;
  stage_word_t word;

  // Take a new word whenever the input register empties this cycle.
  assign in_ready_o = !word_valid || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  wrc_front #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_accept_i       (in_accept),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .stored_checksum_i (stored_checksum_i),
    .advance_i         (advance),
    .word_valid_o      (word_valid),
    .word_o            (word)
  );

  // Accumulate, and hold the final sum until the consumer takes it.
  wrc_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_valid_i  (word_valid),
    .word_i        (word),
    .advance_o     (advance),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .checksum_o    (checksum_o),
    .matches_res_o (matches_res_o)
  );

endmodule
